### hw/rtl/olr_pkg.sv
// Shared types, sizes and the tanh table of the overdub loop recorder.
package olr_pkg;

    localparam int ADDR_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_W    = 8;
    localparam int PH_W      = ADDR_W + FRAC_W;
    localparam int SPEED_W   = 12;
    localparam int POS_W     = 17;
    localparam int TDATA_W   = 64;
    localparam int TUSER_W   = 2;
    localparam int OUT_W     = 16;

    // Bit positions of the flags in the input tuser.
    localparam int TUSER_REC = 0;
    localparam int TUSER_CLR = 1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic rd_b;
        logic calc;
        logic clr_wr;
        logic out_load;
    } olr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic silent;
        logic clr_edge;
        logic clr_last;
        logic out_free;
    } olr_stat_t;

    // Q0.15 tanh(k/16) for k = 0..32.
    function automatic logic [14:0] tanh_q15(input logic [5:0] k);
        logic [14:0] y;
        case (k)
            6'd0: y = 15'd0;
            6'd1: y = 15'd2045;
            6'd2: y = 15'd4075;
            6'd3: y = 15'd6073;
            6'd4: y = 15'd8025;
            6'd5: y = 15'd9919;
            6'd6: y = 15'd11743;
            6'd7: y = 15'd13486;
            6'd8: y = 15'd15143;
            6'd9: y = 15'd16706;
            6'd10: y = 15'd18173;
            6'd11: y = 15'd19542;
            6'd12: y = 15'd20813;
            6'd13: y = 15'd21986;
            6'd14: y = 15'd23066;
            6'd15: y = 15'd24054;
            6'd16: y = 15'd24956;
            6'd17: y = 15'd25776;
            6'd18: y = 15'd26519;
            6'd19: y = 15'd27191;
            6'd20: y = 15'd27797;
            6'd21: y = 15'd28341;
            6'd22: y = 15'd28830;
            6'd23: y = 15'd29268;
            6'd24: y = 15'd29660;
            6'd25: y = 15'd30010;
            6'd26: y = 15'd30322;
            6'd27: y = 15'd30600;
            6'd28: y = 15'd30847;
            6'd29: y = 15'd31067;
            6'd30: y = 15'd31262;
            6'd31: y = 15'd31435;
            6'd32: y = 15'd31589;
            default: y = 15'd31589;
        endcase
        return y;
    endfunction

endpackage

### hw/rtl/olr_ctrl.sv
// Controller state machine of the overdub loop recorder.
module olr_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  olr_pkg::olr_stat_t stat,
    output olr_pkg::olr_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PREP,
        ST_RDA,
        ST_RDB,
        ST_CLR,
        ST_CALC,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_RDA;
            end
            ST_RDA:
            begin
                if (stat.silent)
                begin
                    state_next = ST_CALC;
                end
                else if (stat.clr_edge)
                begin
                    state_next = ST_CLR;
                end
                else
                begin
                    state_next = ST_RDB;
                end
            end
            ST_RDB:
            begin
                cmd.rd_b   = 1'b1;
                state_next = ST_CALC;
            end
            ST_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The result register is loaded only when its slot is free.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a pending transaction");

    // The memory sweep never coincides with accepting a transaction.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> !s_tready)
        else $error("input accepted during memory clear");

endmodule

### hw/rtl/olr_datapath.sv
// Datapath of the overdub loop recorder: loop memory, playhead and arithmetic.
module olr_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  olr_pkg::olr_cmd_t             cmd,
    output olr_pkg::olr_stat_t            stat,
    input  logic [olr_pkg::TDATA_W-1:0]   s_tdata,
    input  logic [olr_pkg::TUSER_W-1:0]   s_tuser,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [olr_pkg::OUT_W-1:0]     m_tdata
);

    localparam int AW  = olr_pkg::ADDR_W;
    localparam int SW  = olr_pkg::SAMPLE_W;
    localparam int FW  = olr_pkg::FRAC_W;
    localparam int PW  = olr_pkg::PH_W;
    localparam int VW  = olr_pkg::SPEED_W;
    localparam int QW  = olr_pkg::POS_W;
    localparam int XW  = PW + 2;
    localparam logic [QW-1:0] POS_ONE = QW'(1) << (QW - 1);
    localparam logic [PW-1:0] PH_MAX  = {{AW{1'b1}}, {FW{1'b0}}};

    // Loop memory.
    logic signed [SW-1:0] mem [2**AW];

    // Input item registers.
    logic signed [SW-1:0] smp_reg;
    logic signed [VW-1:0] spd_reg;
    logic [QW-1:0]        st_reg;
    logic [QW-1:0]        en_reg;
    logic                 rec_reg;
    logic                 clr_reg;

    // Prepared loop bounds and flags.
    logic [AW-1:0] sp_reg;
    logic [AW-1:0] ep_reg;
    logic          silent_reg;
    logic          clr_edge_reg;
    logic [PW-1:0] ph_eff_reg;

    // Persistent state.
    logic [PW-1:0] ph_reg;
    logic          be_reg;
    logic          prev_rec_reg;
    logic          prev_clr_reg;
    logic [AW-1:0] clr_cnt_reg;

    // Read path and result.
    logic signed [SW-1:0] rdata_reg;
    logic signed [SW-1:0] a_reg;
    logic signed [SW-1:0] res_reg;
    logic                 out_valid_reg;
    logic [SW-1:0]        out_data_reg;

    // Bound preparation.
    logic [QW-1:0] st_c, en_c, lo_q, hi_q;
    logic [33:0]   sp_w, ep_w;
    logic [AW-1:0] sp_c, ep_c, span_c;
    logic [VW:0]   spd_neg;
    logic [VW-1:0] aspd;
    logic          silent_c;

    always_comb
    begin
        st_c    = (st_reg > POS_ONE) ? POS_ONE : st_reg;
        en_c    = (en_reg > POS_ONE) ? POS_ONE : en_reg;
        lo_q    = (st_c > en_c) ? en_c : st_c;
        hi_q    = (st_c > en_c) ? st_c : en_c;
        // (DEPTH-1)*f + half, scaled down by 2^16.
        sp_w    = ({lo_q, 16'b0} - 34'(lo_q) + 34'd32768) >> 16;
        ep_w    = ({hi_q, 16'b0} - 34'(hi_q) + 34'd32768) >> 16;
        sp_c    = sp_w[AW-1:0];
        ep_c    = ep_w[AW-1:0];
        span_c  = ep_c - sp_c;
        spd_neg = -{spd_reg[VW-1], spd_reg};
        aspd    = spd_reg[VW-1] ? spd_neg[VW-1:0] : spd_reg;
        silent_c = ({span_c, {FW{1'b0}}} <= PW'(aspd));
    end

    // Tanh overdub of the word at the playhead.
    logic signed [SW:0]  tx;
    logic [SW:0]         tmag;
    logic [4:0]          ti;
    logic [14:0]         tlo, thi, tdiff, ty;
    logic [25:0]         tprod;
    logic [SW-1:0]       tres;

    always_comb
    begin
        tx    = (SW+1)'(a_reg) + (SW+1)'(smp_reg);
        tmag  = tx[SW] ? (SW+1)'(-tx) : tx;
        ti    = tmag[15:11];
        tlo   = olr_pkg::tanh_q15({1'b0, ti});
        thi   = olr_pkg::tanh_q15({1'b0, ti} + 6'd1);
        tdiff = thi - tlo;
        tprod = 26'(tdiff) * 26'(tmag[10:0]) + 26'd1024;
        ty    = tmag[SW] ? olr_pkg::tanh_q15(6'd32) : tlo + 15'(tprod >> 11);
        tres  = tx[SW] ? -{1'b0, ty} : {1'b0, ty};
    end

    // Linear interpolation plus the live sample, saturated.
    logic signed [SW:0]   idiff;
    logic signed [25:0]   ifrac, iprod, ishift;
    logic signed [SW+2:0] isum;
    logic signed [SW-1:0] ires;

    always_comb
    begin
        idiff  = (SW+1)'(rdata_reg) - (SW+1)'(a_reg);
        ifrac  = {{(26-FW){1'b0}}, ph_eff_reg[FW-1:0]};
        iprod  = 26'(idiff) * ifrac + 26'sd128;
        ishift = iprod >>> FW;
        isum   = (SW+3)'(a_reg) + (SW+3)'(ishift) + (SW+3)'(smp_reg);
        if (isum > (SW+3)'(32767))
        begin
            ires = 16'sh7FFF;
        end
        else if (isum < -(SW+3)'(32768))
        begin
            ires = 16'sh8000;
        end
        else
        begin
            ires = SW'(isum);
        end
    end

    // Playhead advance and wrap.
    logic signed [13:0] step;
    logic signed [XW-1:0] phn, sp_fx, ep_fx, phw;

    always_comb
    begin
        if (rec_reg)
        begin
            step = (spd_reg > 0) ? 14'sd256 : -14'sd256;
        end
        else
        begin
            step = spd_reg[VW-1] ? -14'(aspd) : 14'(aspd);
        end
        phn   = XW'(ph_eff_reg) + XW'(step);
        sp_fx = XW'({sp_reg, {FW{1'b0}}});
        ep_fx = XW'({ep_reg, {FW{1'b0}}});
        if (phn > ep_fx)
        begin
            phw = sp_fx + phn - ep_fx;
        end
        else if (phn < sp_fx)
        begin
            phw = ep_fx - sp_fx + phn;
        end
        else
        begin
            phw = phn;
        end
    end

    // Result of the current item.
    logic signed [SW-1:0] res_c;
    always_comb
    begin
        if (silent_reg)
        begin
            res_c = '0;
        end
        else if (rec_reg)
        begin
            res_c = tres;
        end
        else if (clr_edge_reg)
        begin
            res_c = smp_reg;
        end
        else
        begin
            res_c = ires;
        end
    end

    // Memory: one registered read, one write.
    logic [AW-1:0] ia, rd_addr;
    assign ia      = ph_eff_reg[PW-1:FW];
    assign rd_addr = cmd.rd_b ? ia + AW'(1) : ia;

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
        if (cmd.clr_wr)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.calc && rec_reg && !silent_reg)
        begin
            mem[ia] <= tres;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_reg <= s_tdata[15:0];
            spd_reg <= s_tdata[27:16];
            st_reg  <= s_tdata[44:28];
            en_reg  <= s_tdata[61:45];
            rec_reg <= s_tuser[olr_pkg::TUSER_REC];
            clr_reg <= s_tuser[olr_pkg::TUSER_CLR];
        end
        if (cmd.prep)
        begin
            sp_reg       <= sp_c;
            ep_reg       <= ep_c;
            silent_reg   <= silent_c;
            clr_edge_reg <= !rec_reg && clr_reg && !prev_clr_reg;
            ph_eff_reg   <= (rec_reg && !prev_rec_reg && be_reg) ?
                            {sp_c, {FW{1'b0}}} : ph_reg;
        end
        if (cmd.rd_b)
        begin
            a_reg <= rdata_reg;
        end
        if (cmd.calc)
        begin
            res_reg <= res_c;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    // Control state: playhead, flags, clear counter, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= '0;
            be_reg        <= 1'b1;
            prev_rec_reg  <= 1'b0;
            prev_clr_reg  <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.calc && !silent_reg)
            begin
                ph_reg       <= PW'(phw);
                prev_rec_reg <= rec_reg;
                prev_clr_reg <= clr_reg;
                if (!rec_reg)
                begin
                    if (clr_edge_reg)
                    begin
                        be_reg <= 1'b1;
                    end
                    else if (prev_rec_reg)
                    begin
                        be_reg <= 1'b0;
                    end
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.silent   = silent_reg;
    assign stat.clr_edge = clr_edge_reg;
    assign stat.clr_last = &clr_cnt_reg;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

    // The playhead never passes the last memory word.
    a_ph_range: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg <= PH_MAX)
        else $error("playhead beyond loop memory");

    // The clear counter moves only while the sweep runs.
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.clr_wr |=> $stable(clr_cnt_reg))
        else $error("clear counter moved outside a sweep");

endmodule

### hw/rtl/overdub_loop_recorder.sv
// Top level of the overdub loop recorder.
//
//   channel   direction  tdata                                   tuser
//   s_*       in         in_sample, speed, loop_start, loop_end  record, clear
//   m_*       out        out_sample                              -
//
// A playing or recording item runs from the accepting cycle through PREP,
// the first read, the second read and CALC to the cycle that loads the
// result; a silent item skips the second read. The loop memory's one read
// port, read for two neighbors in turn, sets this. A rising clear while
// playing replaces the second read with a sweep that clears the whole memory.
// After reset the same sweep runs before s_tready rises.
// A result waiting on m_tready does not block acceptance of the next transaction.
module overdub_loop_recorder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // in_sample, speed, loop_start, loop_end, zero pad
    input  logic [1:0]  s_tuser,   // record, clear
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // out_sample
);

    olr_pkg::olr_cmd_t  cmd;
    olr_pkg::olr_stat_t stat;

    olr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    olr_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
